### hw/rtl/kscl_pkg.sv
// Shared types, constants and helper functions for the keypad scanner with code lock.
// No dependencies; every other RTL file imports this package.
package kscl_pkg;

   localparam int COL_COUNT      = 4;
   localparam int ROW_COUNT      = 4;
   localparam int CODE_LEN       = 4;
   localparam int CHAR_WIDTH     = 8;
   localparam int SCAN_GAP_WIDTH = 16;
   localparam int ENTRY_IDX_W    = 2;
   localparam int DIGITS_WIDTH   = 3;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   // Register indexes (byte address / 4)
   localparam logic [2:0] REG_CODE_CHAR_0 = 3'd0;
   localparam logic [2:0] REG_CODE_CHAR_1 = 3'd1;
   localparam logic [2:0] REG_CODE_CHAR_2 = 3'd2;
   localparam logic [2:0] REG_CODE_CHAR_3 = 3'd3;
   localparam logic [2:0] REG_SCAN_GAP    = 3'd4;

   localparam logic [CHAR_WIDTH-1:0]     CODE_CHAR_0_RST = 8'd48;
   localparam logic [CHAR_WIDTH-1:0]     CODE_CHAR_1_RST = 8'd65;
   localparam logic [CHAR_WIDTH-1:0]     CODE_CHAR_2_RST = 8'd56;
   localparam logic [CHAR_WIDTH-1:0]     CODE_CHAR_3_RST = 8'd67;
   localparam logic [SCAN_GAP_WIDTH-1:0] SCAN_GAP_RST    = 16'd10;

   localparam logic [COL_COUNT-1:0] ALL_HIGH = 4'hF;

   typedef enum logic [1:0] {
      PH_GAP,
      PH_SCAN,
      PH_RELEASE
   } phase_type;

   // Key found under a driven row, handed from scanner to code lock
   typedef struct packed {
      logic       valid;
      logic [3:0] key;
   } key_evt_type;

   typedef logic [CODE_LEN-1:0][CHAR_WIDTH-1:0] code_type;

   function automatic logic [CHAR_WIDTH-1:0] key_char_of(input logic [3:0] key);
      logic [CHAR_WIDTH-1:0] ch;
      case (key)
         4'd0:    ch = 8'h31; // '1'
         4'd1:    ch = 8'h32; // '2'
         4'd2:    ch = 8'h33; // '3'
         4'd3:    ch = 8'h41; // 'A'
         4'd4:    ch = 8'h34; // '4'
         4'd5:    ch = 8'h35; // '5'
         4'd6:    ch = 8'h36; // '6'
         4'd7:    ch = 8'h42; // 'B'
         4'd8:    ch = 8'h37; // '7'
         4'd9:    ch = 8'h38; // '8'
         4'd10:   ch = 8'h39; // '9'
         4'd11:   ch = 8'h43; // 'C'
         4'd12:   ch = 8'h2A; // '*'
         4'd13:   ch = 8'h30; // '0'
         4'd14:   ch = 8'h23; // '#'
         default: ch = 8'h44; // 'D'
      endcase
      return ch;
   endfunction

   // Active-low drive pattern for one row
   function automatic logic [ROW_COUNT-1:0] row_drive_of(input logic [1:0] row);
      return ALL_HIGH & ~(4'b0001 << row);
   endfunction

   // Lowest-numbered low column; column 4 when only it is low or when none is low
   function automatic logic [1:0] first_low_col(input logic [COL_COUNT-1:0] cols);
      logic [1:0] c;
      if (!cols[0]) begin
         c = 2'd0;
      end else if (!cols[1]) begin
         c = 2'd1;
      end else if (!cols[2]) begin
         c = 2'd2;
      end else begin
         c = 2'd3;
      end
      return c;
   endfunction

endpackage

### hw/rtl/keypad_scan_code_lock_top.sv
// 4x4 keypad scanner with code lock: top level, CSR block, input and result registers.
// Depends on kscl_pkg, kscl_scan and kscl_lock.
//
// Each word on the req channel is one scan tick: the column levels read under the
// row pattern carried by the previous rsp word. Every req word yields exactly one
// rsp word. The block idles scan_gap ticks with all rows high, then drives rows
// 1..4 low one per tick; the first low column selects a key, the row is held until
// all columns read high, and the release tick reports the key's ASCII character.
// After four characters the entry is compared with the code registers; entry_done
// is raised on that word, with code_match when the entry matches. A word accepted
// lands in the input register and moves into the result register when that one is
// free or draining, and its rsp word is then valid; a new word is taken every
// cycle while the result register is free or draining, and req_stall rises only
// when both registers hold a word and rsp_stall is high. Throughput is one word
// per clock while the result register is not stalled, set by the state update
// between the two registers. CSR map (byte address): 0x00..0x0C code characters
// 1..4, 0x10 scan_gap. Write CSRs only when the block is idle.
module keypad_scan_code_lock_top
   import kscl_pkg::*;
#(
   parameter int GAP_COUNT_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   // scan tick input
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [COL_COUNT-1:0]      req_column_levels,
   // result output
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [ROW_COUNT-1:0]      rsp_row_drive,
   output logic                      rsp_key_valid,
   output logic [CHAR_WIDTH-1:0]     rsp_key_char,
   output logic                      rsp_entry_done,
   output logic                      rsp_code_match,
   output logic [DIGITS_WIDTH-1:0]   rsp_digits_entered,
   // register port
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   // ---------------------------------------------------------------- CSRs
   code_type                  code_ff;
   logic [SCAN_GAP_WIDTH-1:0] scan_gap_ff;
   logic                      csr_wr;
   logic [2:0]                csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[CSR_ADDR_WIDTH-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff[0]  <= CODE_CHAR_0_RST;
         code_ff[1]  <= CODE_CHAR_1_RST;
         code_ff[2]  <= CODE_CHAR_2_RST;
         code_ff[3]  <= CODE_CHAR_3_RST;
         scan_gap_ff <= SCAN_GAP_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_CODE_CHAR_0: code_ff[0]  <= pwdata[CHAR_WIDTH-1:0];
            REG_CODE_CHAR_1: code_ff[1]  <= pwdata[CHAR_WIDTH-1:0];
            REG_CODE_CHAR_2: code_ff[2]  <= pwdata[CHAR_WIDTH-1:0];
            REG_CODE_CHAR_3: code_ff[3]  <= pwdata[CHAR_WIDTH-1:0];
            REG_SCAN_GAP:    scan_gap_ff <= pwdata[SCAN_GAP_WIDTH-1:0];
            default: ;  // unmapped: drop the write
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_CODE_CHAR_0: prdata = CSR_DATA_WIDTH'(code_ff[0]);
         REG_CODE_CHAR_1: prdata = CSR_DATA_WIDTH'(code_ff[1]);
         REG_CODE_CHAR_2: prdata = CSR_DATA_WIDTH'(code_ff[2]);
         REG_CODE_CHAR_3: prdata = CSR_DATA_WIDTH'(code_ff[3]);
         REG_SCAN_GAP:    prdata = CSR_DATA_WIDTH'(scan_gap_ff);
         default:         prdata = '0;
      endcase
   end

   // ------------------------------------------------------ pipeline control
   // Stage 1 holds the accepted word; it advances into the result register
   // whenever that register is empty or being drained this cycle.
   logic                 in_valid_ff;
   logic [COL_COUNT-1:0] in_cols_ff;
   logic                 out_ready;
   logic                 step;
   logic                 req_take;

   assign out_ready = !rsp_valid || !rsp_stall;
   assign step      = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cols_ff <= req_column_levels;
      end
   end

   // ------------------------------------------------------------ datapath
   key_evt_type             key_evt;
   logic [ROW_COUNT-1:0]    row_drive;
   logic                    key_valid;
   logic [CHAR_WIDTH-1:0]   key_char;
   logic                    entry_done;
   logic                    code_match;
   logic [DIGITS_WIDTH-1:0] digits_entered;

   kscl_scan #(
      .GAP_COUNT_WIDTH (GAP_COUNT_WIDTH)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .cols      (in_cols_ff),
      .scan_gap  (scan_gap_ff),
      .row_drive (row_drive),
      .key_evt   (key_evt)
   );

   kscl_lock u_lock (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .key_evt        (key_evt),
      .code           (code_ff),
      .key_valid      (key_valid),
      .key_char       (key_char),
      .entry_done     (entry_done),
      .code_match     (code_match),
      .digits_entered (digits_entered)
   );

   // ------------------------------------------------------- result register
   logic                    rsp_valid_ff;
   logic [ROW_COUNT-1:0]    row_drive_ff;
   logic                    key_valid_ff;
   logic [CHAR_WIDTH-1:0]   key_char_ff;
   logic                    entry_done_ff;
   logic                    code_match_ff;
   logic [DIGITS_WIDTH-1:0] digits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   // Hold the word while the consumer stalls.
   always_ff @(posedge clock) begin
      if (step) begin
         row_drive_ff  <= row_drive;
         key_valid_ff  <= key_valid;
         key_char_ff   <= key_char;
         entry_done_ff <= entry_done;
         code_match_ff <= code_match;
         digits_ff     <= digits_entered;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_row_drive      = row_drive_ff;
   assign rsp_key_valid      = key_valid_ff;
   assign rsp_key_char       = key_char_ff;
   assign rsp_entry_done     = entry_done_ff;
   assign rsp_code_match     = code_match_ff;
   assign rsp_digits_entered = digits_ff;

endmodule

### hw/rtl/kscl_scan.sv
// Row scan sequencer: gap timer, row stepping, key capture and release wait.
// Depends on kscl_pkg.
module kscl_scan
   import kscl_pkg::*;
#(
   parameter int GAP_COUNT_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [COL_COUNT-1:0]      cols,
   input  logic [SCAN_GAP_WIDTH-1:0] scan_gap,
   output logic [ROW_COUNT-1:0]      row_drive,
   output key_evt_type               key_evt
);

   localparam int CMP_WIDTH = (GAP_COUNT_WIDTH > SCAN_GAP_WIDTH) ?
                              GAP_COUNT_WIDTH : SCAN_GAP_WIDTH;

   phase_type                  phase_ff, phase_in;
   logic [1:0]                 row_ff, row_in;
   logic [GAP_COUNT_WIDTH-1:0] gap_ff, gap_in;
   logic [3:0]                 held_ff, held_in;
   logic                       gap_running;

   assign gap_running = (CMP_WIDTH'(gap_ff) < CMP_WIDTH'(scan_gap)) && (gap_ff != '1);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_GAP;
         row_ff   <= '0;
         gap_ff   <= '0;
         held_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         row_ff   <= row_in;
         gap_ff   <= gap_in;
         held_ff  <= held_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      row_in    = row_ff;
      gap_in    = gap_ff;
      held_in   = held_ff;
      row_drive = ALL_HIGH;
      key_evt   = '0;
      unique case (phase_ff)
         PH_SCAN: begin
            if (cols != ALL_HIGH) begin
               held_in   = {row_ff, first_low_col(cols)};
               phase_in  = PH_RELEASE;
               row_drive = row_drive_of(row_ff);
            end else if (row_ff != 2'd3) begin
               row_in    = row_ff + 2'd1;
               row_drive = row_drive_of(row_in);
            end else begin
               phase_in = PH_GAP;
               gap_in   = '0;
            end
         end
         PH_RELEASE: begin
            if (cols == ALL_HIGH) begin
               key_evt.valid = 1'b1;
               key_evt.key   = held_ff;
               phase_in      = PH_GAP;
               gap_in        = '0;
            end else begin
               row_drive = row_drive_of(row_ff);
            end
         end
         default: begin
            if (gap_running) begin
               gap_in = gap_ff + GAP_COUNT_WIDTH'(1);
            end else begin
               gap_in    = '0;
               phase_in  = PH_SCAN;
               row_in    = 2'd0;
               row_drive = row_drive_of(2'd0);
            end
         end
      endcase
   end

endmodule

### hw/rtl/kscl_lock.sv
// Code entry store and compare: keeps four entered characters, flags match on the fourth.
// Depends on kscl_pkg.
module kscl_lock
   import kscl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  key_evt_type             key_evt,
   input  code_type                code,
   output logic                    key_valid,
   output logic [CHAR_WIDTH-1:0]   key_char,
   output logic                    entry_done,
   output logic                    code_match,
   output logic [DIGITS_WIDTH-1:0] digits_entered
);

   logic [CHAR_WIDTH-1:0]  entered_ff [CODE_LEN];
   logic [ENTRY_IDX_W-1:0] count_ff, count_in;
   logic [CHAR_WIDTH-1:0]  ch;
   logic                   last;

   assign ch   = key_char_of(key_evt.key);
   assign last = (count_ff == ENTRY_IDX_W'(CODE_LEN - 1));

   always_comb begin
      key_valid      = key_evt.valid;
      key_char       = key_evt.valid ? ch : '0;
      entry_done     = key_evt.valid && last;
      code_match     = entry_done &&
                       (entered_ff[0] == code[0]) &&
                       (entered_ff[1] == code[1]) &&
                       (entered_ff[2] == code[2]) &&
                       (ch == code[3]);
      digits_entered = DIGITS_WIDTH'(count_ff) + (key_evt.valid ? 3'd1 : 3'd0);
      // wraps to zero after the fourth character
      count_in       = key_evt.valid ? count_ff + ENTRY_IDX_W'(1) : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (step) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && key_evt.valid) begin
         entered_ff[count_ff] <= ch;
      end
   end

endmodule

### hw/rtl/kscl_checker.sv
// Port-level checks for the keypad scanner, bound onto the top level.
// Depends on kscl_pkg and keypad_scan_code_lock_top.
module kscl_port_checks
   import kscl_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [ROW_COUNT-1:0]      rsp_row_drive,
   input logic                      rsp_key_valid,
   input logic [CHAR_WIDTH-1:0]     rsp_key_char,
   input logic                      rsp_entry_done,
   input logic                      rsp_code_match,
   input logic [DIGITS_WIDTH-1:0]   rsp_digits_entered
);

   // a stalled result word stays valid and holds its character, row drive and digit count
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_key_char) &&
                                 $stable(rsp_row_drive) && $stable(rsp_digits_entered))
      else $error("result word changed while stalled");

   // a completed entry always comes with its fourth key report
   a_done_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_done |-> rsp_key_valid && rsp_digits_entered == 3'd4)
      else $error("entry_done without fourth key");

   // a key is only reported on release, when no row is driven
   a_key_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_key_valid |-> rsp_row_drive == ALL_HIGH)
      else $error("key reported while a row is driven");

   // match is only flagged at the end of an entry
   a_match_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_entry_done |-> !rsp_code_match)
      else $error("code_match outside entry_done");

   // no character without a key report
   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_key_valid |-> rsp_key_char == '0)
      else $error("key_char set without key_valid");

endmodule

bind keypad_scan_code_lock_top kscl_port_checks u_port_checks (.*);
